/* hdl/assert_macros.svh */
// Assertion macros shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* hdl/odcc_pkg.sv */
`default_nettype none
package odcc_pkg;
   typedef struct packed {
      logic [7:0]  opcode;
      logic [1:0]  param_count;
      logic [7:0]  param_first;
      logic [7:0]  param_second;
      logic [7:0]  param_third;
      logic        phase;
      logic        track_found;
      logic [18:0] track_start;
   } req_type;

   typedef struct packed {
      logic [7:0] response_byte;
      logic [1:0] irq_kind;
      logic       last;
      logic       want_second_phase;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_CALC, ST_BUILD, ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       exec;
      logic       emit;
      logic       advance;
   } ctl_type;

   typedef struct packed {
      logic       has_rsp;
      logic       emit_last;
   } sts_type;

   localparam logic [1:0] CSR_FIRST_TRACK = 2'd0;
   localparam logic [1:0] CSR_LAST_TRACK  = 2'd1;
   localparam logic [1:0] CSR_LEAD_OUT    = 2'd2;
   localparam logic [1:0] CSR_REGION      = 2'd3;

   localparam logic [1:0] IRQ_ACK   = 2'd1;
   localparam logic [1:0] IRQ_DONE  = 2'd2;
   localparam logic [1:0] IRQ_ERROR = 2'd3;

   localparam logic [7:0] OP_GETSTAT  = 8'h01;
   localparam logic [7:0] OP_SETLOC   = 8'h02;
   localparam logic [7:0] OP_PLAY     = 8'h03;
   localparam logic [7:0] OP_FORWARD  = 8'h04;
   localparam logic [7:0] OP_BACKWARD = 8'h05;
   localparam logic [7:0] OP_READN    = 8'h06;
   localparam logic [7:0] OP_MOTORON  = 8'h07;
   localparam logic [7:0] OP_STOP     = 8'h08;
   localparam logic [7:0] OP_PAUSE    = 8'h09;
   localparam logic [7:0] OP_INIT     = 8'h0a;
   localparam logic [7:0] OP_MUTE     = 8'h0b;
   localparam logic [7:0] OP_DEMUTE   = 8'h0c;
   localparam logic [7:0] OP_SETMODE  = 8'h0e;
   localparam logic [7:0] OP_GETTN    = 8'h13;
   localparam logic [7:0] OP_GETTD    = 8'h14;
   localparam logic [7:0] OP_SEEKL    = 8'h15;
   localparam logic [7:0] OP_SEEKP    = 8'h16;
   localparam logic [7:0] OP_TEST     = 8'h19;
   localparam logic [7:0] OP_GETID    = 8'h1a;

   localparam logic [19:0] PREGAP     = 20'd150;
   localparam logic [18:0] SECTOR_MAX = 19'h7ffff;

   // Reciprocals for division by 4500 (shift 33) and by 75 (shift 27),
   // exact for any dividend below 2**20.
   localparam logic [40:0] RECIP_4500 = 41'd1908875;
   localparam logic [40:0] RECIP_75   = 41'd1789570;

   function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  t;
      logic [6:0]  r;
      prod = 15'(v) * 15'd205;
      t = prod[14:11];
      r = v - 7'(t) * 7'd10;
      return {t, r[3:0]};
   endfunction

   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
   endfunction
endpackage
`default_nettype wire

/* hdl/odcc_datapath.sv */
`default_nettype none
module odcc_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire odcc_pkg::req_type req,
   input  wire odcc_pkg::ctl_type ctl,
   output      odcc_pkg::sts_type sts,
   input  wire logic            csr_write_enable,
   input  wire logic [1:0]      csr_index,
   input  wire logic [18:0]     csr_write_data,
   output      odcc_pkg::rsp_type rsp
);
   import odcc_pkg::*;

   req_type     req_ff;
   logic [6:0]  first_ff, last_trk_ff;
   logic [18:0] lead_ff;
   logic [1:0]  region_ff;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  mode_ff, mode_in;
   logic [18:0] reqsec_ff, reqsec_in;
   logic [18:0] cursec_ff, cursec_in;
   logic [1:0]  play_ff, play_in;
   logic [7:0]  buf_ff [8];
   logic [7:0]  buf_in [8];
   logic [3:0]  cnt_ff, cnt_in;
   logic [2:0]  idx_ff;
   logic [1:0]  irq_ff, irq_in;
   logic        want_ff, want_in;
   logic [7:0]  p0, p1, p2;
   logic [19:0] lba_ff;
   logic [19:0] lba_calc;
   logic [19:0] td_calc;
   logic [40:0] min_prod;
   logic [40:0] q75_prod;
   logic [6:0]  minute_ff;
   logic [12:0] q75_ff;
   logic [12:0] sec_wide;
   logic [6:0]  secs_all;

   assign p0 = req_ff.param_count >= 2'd1 ? req_ff.param_first  : 8'd0;
   assign p1 = req_ff.param_count >= 2'd2 ? req_ff.param_second : 8'd0;
   assign p2 = req_ff.param_count == 2'd3 ? req_ff.param_third  : 8'd0;

   // Sector arithmetic is registered in the calculate cycle, ahead of the response build.
   always_comb begin
      lba_calc = 20'(bcd_to_bin(p0)) * 20'd4500 + 20'(bcd_to_bin(p1)) * 20'd75
               + 20'(bcd_to_bin(p2));
      if (p0 == 8'd0) td_calc = 20'(lead_ff);
      else if (req_ff.track_found) td_calc = 20'(req_ff.track_start);
      else td_calc = 20'd0;
      td_calc  = td_calc + PREGAP;
      min_prod = 41'(td_calc) * RECIP_4500;
      q75_prod = 41'(td_calc) * RECIP_75;
   end

   always_comb begin
      sec_wide = q75_ff - 13'(minute_ff) * 13'd60;
      secs_all = sec_wide[6:0];
   end

   always_comb begin
      status_in = status_ff;
      mode_in   = mode_ff;
      reqsec_in = reqsec_ff;
      cursec_in = cursec_ff;
      play_in   = play_ff;
      cnt_in    = 4'd0;
      irq_in    = IRQ_ACK;
      want_in   = 1'b0;
      for (int i = 0; i < 8; i++) buf_in[i] = 8'd0;
      unique case (req_ff.opcode)
         OP_GETSTAT: begin
            buf_in[0] = status_ff; cnt_in = 4'd1; status_in = status_ff & ~8'h10;
         end
         OP_SETLOC: begin
            if (lba_ff < PREGAP) reqsec_in = 19'd0;
            else if (lba_ff - PREGAP > 20'(SECTOR_MAX)) reqsec_in = SECTOR_MAX;
            else reqsec_in = 19'(lba_ff - PREGAP);
            buf_in[0] = status_ff; cnt_in = 4'd1;
         end
         OP_PLAY: begin
            if (req_ff.param_count != 2'd0 && req_ff.track_found)
               cursec_in = req_ff.track_start;
            status_in = status_ff | 8'ha0; play_in = 2'd0;
            buf_in[0] = status_in; cnt_in = 4'd1;
         end
         OP_FORWARD, OP_BACKWARD: begin
            play_in = req_ff.opcode == OP_FORWARD ? 2'd1 : 2'd2;
            buf_in[0] = status_ff; cnt_in = 4'd1;
         end
         OP_READN, OP_MOTORON: begin
            cursec_in = reqsec_ff; status_in = status_ff | 8'h20;
            buf_in[0] = status_in; cnt_in = 4'd1;
         end
         OP_STOP, OP_PAUSE: begin
            if (!req_ff.phase) want_in = 1'b1;
            else begin
               status_in = status_ff & (req_ff.opcode == OP_STOP ? ~8'h80 : ~8'h20);
               irq_in = IRQ_DONE;
            end
            buf_in[0] = status_in; cnt_in = 4'd1;
         end
         OP_INIT: begin
            if (!req_ff.phase) begin
               mode_in = 8'd0; status_in = (status_ff | 8'h02) & ~8'h60; want_in = 1'b1;
            end else irq_in = IRQ_DONE;
            buf_in[0] = status_in; cnt_in = 4'd1;
         end
         OP_MUTE, OP_DEMUTE: begin
            buf_in[0] = status_ff; cnt_in = 4'd1;
         end
         OP_SETMODE: begin
            mode_in = p0; buf_in[0] = status_ff; cnt_in = 4'd1;
         end
         OP_GETTN: begin
            buf_in[0] = status_ff; buf_in[1] = bin_to_bcd(first_ff);
            buf_in[2] = bin_to_bcd(last_trk_ff); cnt_in = 4'd3;
         end
         OP_GETTD: begin
            buf_in[0] = status_ff;
            buf_in[1] = bin_to_bcd(minute_ff);
            buf_in[2] = bin_to_bcd(secs_all); cnt_in = 4'd3;
         end
         OP_SEEKL, OP_SEEKP: begin
            cursec_in = reqsec_ff;
            if (req_ff.opcode == OP_SEEKP) status_in = status_ff & ~8'h80;
            buf_in[0] = status_in; cnt_in = 4'd1; irq_in = IRQ_DONE;
         end
         OP_TEST: begin
            if (p0 == 8'h20) begin
               buf_in[0] = 8'h95; buf_in[1] = 8'h05; buf_in[2] = 8'h16;
               buf_in[3] = 8'hc1; cnt_in = 4'd4;
            end
         end
         OP_GETID: begin
            if (!req_ff.phase) begin
               buf_in[0] = status_ff; cnt_in = 4'd1; want_in = 1'b1;
            end else if (region_ff != 2'd3) begin
               status_in = status_ff & ~8'h08;
               buf_in[0] = status_in; buf_in[2] = 8'h20; buf_in[4] = 8'h53;
               buf_in[5] = 8'h43; buf_in[6] = 8'h45;
               buf_in[7] = region_ff == 2'd0 ? 8'h49 : (region_ff == 2'd1 ? 8'h41 : 8'h45);
               cnt_in = 4'd8; irq_in = IRQ_DONE;
            end else begin
               status_in = status_ff | 8'h08;
               buf_in[0] = status_in; buf_in[1] = 8'h90;
               cnt_in = 4'd8; irq_in = IRQ_ERROR;
            end
         end
         default: cnt_in = 4'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req;
      if (ctl.exec) begin
         lba_ff    <= lba_calc;
         minute_ff <= min_prod[39:33];
         q75_ff    <= q75_prod[39:27];
      end
      if (ctl.emit) buf_ff <= buf_in;
      if (ctl.emit) irq_ff <= irq_in;
      if (ctl.emit) want_ff <= want_in;
      if (reset) begin
         first_ff <= 7'd1; last_trk_ff <= 7'd1; lead_ff <= 19'd0; region_ff <= 2'd3;
         status_ff <= 8'd0; mode_ff <= 8'd0; reqsec_ff <= 19'd0; cursec_ff <= 19'd0;
         play_ff <= 2'd0; cnt_ff <= 4'd0; idx_ff <= 3'd0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FIRST_TRACK: first_ff    <= csr_write_data[6:0];
               CSR_LAST_TRACK:  last_trk_ff <= csr_write_data[6:0];
               CSR_LEAD_OUT:    lead_ff     <= csr_write_data;
               CSR_REGION:      region_ff   <= csr_write_data[1:0];
               default: ;
            endcase
         end
         if (ctl.emit) begin
            status_ff <= status_in; mode_ff <= mode_in; reqsec_ff <= reqsec_in;
            cursec_ff <= cursec_in; play_ff <= play_in; cnt_ff <= cnt_in;
            idx_ff <= 3'd0;
         end else if (ctl.advance) begin
            idx_ff <= idx_ff + 3'd1;
            if (sts.emit_last) cnt_ff <= 4'd0;
         end
      end
   end

   assign sts.has_rsp   = cnt_ff != 4'd0;
   assign sts.emit_last = 4'(idx_ff) + 4'd1 == cnt_ff;
   assign rsp.response_byte     = buf_ff[idx_ff];
   assign rsp.last              = sts.emit_last;
   assign rsp.irq_kind          = sts.emit_last ? irq_ff : 2'd0;
   assign rsp.want_second_phase = sts.emit_last & want_ff;
   logic unused_ok;
   assign unused_ok = ^{mode_ff, play_ff, cursec_ff, min_prod[40], min_prod[32:0],
                        q75_prod[40], q75_prod[26:0], sec_wide[12:7]};
endmodule
`default_nettype wire

/* hdl/odcc_control.sv */
`default_nettype none
module odcc_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic              rsp_ready,
   output      logic              rsp_valid,
   input  wire odcc_pkg::sts_type sts,
   output      odcc_pkg::ctl_type ctl
);
   import odcc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1; state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            ctl.exec = 1'b1; state_in = ST_BUILD;
         end
         ST_BUILD: begin
            ctl.emit = 1'b1; state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.has_rsp) state_in = ST_IDLE;
            else begin
               rsp_valid   = 1'b1;
               ctl.advance = rsp_ready;
               if (rsp_ready && sts.emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* hdl/optical_drive_command_controller.sv */
// Optical drive command processor.
// A command is a transfer on the req_ channel (valid/ready). The block
// executes it, updating status, mode and sector state, and then returns
// its response bytes as transfers on the rsp_ channel, one per cycle
// while rsp_ready is high; the final byte carries last, the interrupt
// kind and the second-phase request. Unknown commands give no bytes.
// Steps: the command is registered, sector arithmetic is formed, and
// the response buffer is built before the first byte is offered.
// Responses have 1 to 8 bytes; the next command is taken once the
// last byte has gone. A stalled receiver simply holds the current byte.
// Synchronous reset returns state to zero and configuration to its
// defaults: first and last track 1, lead-out 0, region unknown.
// Configuration writes through csr_ take effect at the next edge.
`default_nettype none
module optical_drive_command_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire odcc_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      odcc_pkg::rsp_type rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [18:0]       csr_write_data
);
   import odcc_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic    rsp_valid_i;

   odcc_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_ready,
      .rsp_valid(rsp_valid_i), .sts, .ctl
   );

   odcc_datapath u_datapath (
      .clock, .reset, .req(req_data), .ctl, .sts,
      .csr_write_enable, .csr_index, .csr_write_data, .rsp(rsp_data)
   );

   assign rsp_valid = rsp_valid_i;
endmodule
`default_nettype wire

/* hdl/odcc_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module odcc_assert_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last
);
   `ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last,
                !rsp_valid)
endmodule
bind optical_drive_command_controller odcc_assert_checker u_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_last(rsp_data.last)
);
`default_nettype wire

/* bench/odcc_checker.sv */
`default_nettype none
module odcc_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire odcc_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire odcc_pkg::rsp_type rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [18:0]       csr_write_data,
   output int                     fail_count,
   output int                     pending_count,
   output int                     byte_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import odcc_pkg::*;

   logic [6:0]  first_trk, last_trk;
   logic [18:0] lead_out;
   logic [1:0]  region;
   logic [7:0]  drive_status, drive_mode;
   logic [18:0] target_sector, head_sector;
   logic [1:0]  audio_mode;
   rsp_type     pending_bytes[$];

   function automatic logic [31:0] from_bcd(input logic [7:0] b);
      return b[7:4] * 10 + b[3:0];
   endfunction

   function automatic logic [7:0] to_bcd(input logic [31:0] v);
      return 8'((((v / 10) << 4) | (v % 10)) & 32'hff);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.response_byte = b;
      pending_bytes.push_back(r);
   endtask

   task automatic close_response(input logic [1:0] irq, input logic want);
      rsp_type r;
      r = pending_bytes.pop_back();
      r.irq_kind = irq;
      r.last = 1'b1;
      r.want_second_phase = want;
      pending_bytes.push_back(r);
   endtask

   task automatic predict_command(input req_type c);
      logic [7:0]  p0, p1, p2;
      logic [31:0] lba;
      logic [7:0]  tags[3];
      tags = '{8'h49, 8'h41, 8'h45};
      p0 = c.param_count >= 1 ? c.param_first : 8'd0;
      p1 = c.param_count >= 2 ? c.param_second : 8'd0;
      p2 = c.param_count >= 3 ? c.param_third : 8'd0;
      case (c.opcode)
         OP_GETSTAT: begin
            push_byte(drive_status);
            drive_status &= ~8'h10;
            close_response(IRQ_ACK, 1'b0);
         end
         OP_SETLOC: begin
            lba = from_bcd(p0) * 4500 + from_bcd(p1) * 75 + from_bcd(p2);
            lba = lba < 150 ? 32'd0 : lba - 150;
            target_sector = lba > 524287 ? 19'h7ffff : lba[18:0];
            push_byte(drive_status);
            close_response(IRQ_ACK, 1'b0);
         end
         OP_PLAY: begin
            if (c.param_count >= 1 && c.track_found) head_sector = c.track_start;
            drive_status |= 8'ha0;
            audio_mode = 2'd0;
            push_byte(drive_status);
            close_response(IRQ_ACK, 1'b0);
         end
         OP_FORWARD, OP_BACKWARD: begin
            audio_mode = c.opcode == OP_FORWARD ? 2'd1 : 2'd2;
            push_byte(drive_status);
            close_response(IRQ_ACK, 1'b0);
         end
         OP_READN, OP_MOTORON: begin
            head_sector = target_sector;
            drive_status |= 8'h20;
            push_byte(drive_status);
            close_response(IRQ_ACK, 1'b0);
         end
         OP_STOP, OP_PAUSE: begin
            if (!c.phase) begin
               push_byte(drive_status);
               close_response(IRQ_ACK, 1'b1);
            end else begin
               drive_status &= c.opcode == OP_STOP ? ~8'h80 : ~8'h20;
               push_byte(drive_status);
               close_response(IRQ_DONE, 1'b0);
            end
         end
         OP_INIT: begin
            if (!c.phase) begin
               drive_mode = 8'd0;
               drive_status = (drive_status | 8'h02) & ~8'h60;
               push_byte(drive_status);
               close_response(IRQ_ACK, 1'b1);
            end else begin
               push_byte(drive_status);
               close_response(IRQ_DONE, 1'b0);
            end
         end
         OP_MUTE, OP_DEMUTE: begin
            push_byte(drive_status);
            close_response(IRQ_ACK, 1'b0);
         end
         OP_SETMODE: begin
            drive_mode = p0;
            push_byte(drive_status);
            close_response(IRQ_ACK, 1'b0);
         end
         OP_GETTN: begin
            push_byte(drive_status);
            push_byte(to_bcd(32'(first_trk)));
            push_byte(to_bcd(32'(last_trk)));
            close_response(IRQ_ACK, 1'b0);
         end
         OP_GETTD: begin
            if (p0 == 8'd0) lba = 32'(lead_out);
            else lba = c.track_found ? 32'(c.track_start) : 32'd0;
            lba += 150;
            push_byte(drive_status);
            push_byte(to_bcd(lba / 4500));
            push_byte(to_bcd((lba / 75) % 60));
            close_response(IRQ_ACK, 1'b0);
         end
         OP_SEEKL, OP_SEEKP: begin
            head_sector = target_sector;
            if (c.opcode == OP_SEEKP) drive_status &= ~8'h80;
            push_byte(drive_status);
            close_response(IRQ_DONE, 1'b0);
         end
         OP_TEST: begin
            if (p0 == 8'h20) begin
               push_byte(8'h95);
               push_byte(8'h05);
               push_byte(8'h16);
               push_byte(8'hc1);
               close_response(IRQ_ACK, 1'b0);
            end
         end
         OP_GETID: begin
            if (!c.phase) begin
               push_byte(drive_status);
               close_response(IRQ_ACK, 1'b1);
            end else if (region <= 2'd2) begin
               drive_status &= ~8'h08;
               push_byte(drive_status);
               push_byte(8'h00);
               push_byte(8'h20);
               push_byte(8'h00);
               push_byte(8'h53);
               push_byte(8'h43);
               push_byte(8'h45);
               push_byte(tags[region]);
               close_response(IRQ_DONE, 1'b0);
            end else begin
               drive_status |= 8'h08;
               push_byte(drive_status);
               push_byte(8'h90);
               repeat (6) push_byte(8'h00);
               close_response(IRQ_ERROR, 1'b0);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         first_trk <= 7'd1;
         last_trk <= 7'd1;
         lead_out <= '0;
         region <= 2'd3;
         drive_status <= '0;
         drive_mode <= '0;
         target_sector <= '0;
         head_sector <= '0;
         audio_mode <= '0;
         pending_bytes.delete();
         fail_count <= 0;
         byte_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FIRST_TRACK: first_trk = csr_write_data[6:0];
               CSR_LAST_TRACK:  last_trk = csr_write_data[6:0];
               CSR_LEAD_OUT:    lead_out = csr_write_data;
               CSR_REGION:      region = csr_write_data[1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_command(req_data);
         if (rsp_valid && rsp_ready) begin
            byte_count <= byte_count + 1;
            if (pending_bytes.size() == 0) begin
               $error("response byte 0x%0h with nothing expected", rsp_data.response_byte);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_bytes.pop_front();
               if (want !== rsp_data) begin
                  if (want.response_byte !== rsp_data.response_byte)
                     $error("response_byte expected 0x%0h got 0x%0h",
                            want.response_byte, rsp_data.response_byte);
                  if (want.irq_kind !== rsp_data.irq_kind)
                     $error("irq_kind expected %0d got %0d", want.irq_kind, rsp_data.irq_kind);
                  if (want.last !== rsp_data.last)
                     $error("last expected %0d got %0d", want.last, rsp_data.last);
                  if (want.want_second_phase !== rsp_data.want_second_phase)
                     $error("want_second_phase expected %0d got %0d",
                            want.want_second_phase, rsp_data.want_second_phase);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = pending_bytes.size();
endmodule
`default_nettype wire

/* bench/optical_drive_command_controller_tb.sv */
`default_nettype none
module optical_drive_command_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import odcc_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [18:0] csr_write_data = '0;
   int          fail_count, pending_count, byte_count;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   int          quiet_cycles = 0;
   int          command_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   optical_drive_command_controller i_dut (.*);

   odcc_checker i_checker (.*);

   always @(posedge clock) begin
      rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_command(input req_type c);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_valid <= 1'b0;
      command_count++;
      @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [18:0] val);
      while (pending_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type make_command(input logic [7:0] op, input logic [1:0] cnt,
                                            input logic ph);
      req_type c;
      c.opcode = op;
      c.param_count = cnt;
      c.param_first = 8'($urandom);
      c.param_second = 8'($urandom);
      c.param_third = 8'($urandom);
      c.phase = ph;
      c.track_found = 1'($urandom);
      c.track_start = 19'($urandom_range(449999));
      return c;
   endfunction

   function automatic req_type random_command();
      logic [7:0] ops[19];
      req_type    c;
      ops = '{OP_GETSTAT, OP_SETLOC, OP_PLAY, OP_FORWARD, OP_BACKWARD, OP_READN,
              OP_MOTORON, OP_STOP, OP_PAUSE, OP_INIT, OP_MUTE, OP_DEMUTE, OP_SETMODE,
              OP_GETTN, OP_GETTD, OP_SEEKL, OP_SEEKP, OP_TEST, OP_GETID};
      c = make_command(ops[$urandom_range(18)], 2'($urandom), 1'($urandom));
      if ($urandom_range(9) == 0) c.opcode = 8'($urandom);
      if (c.opcode == OP_TEST && $urandom_range(2) != 0) c.param_first = 8'h20;
      if (c.opcode == OP_GETTD && $urandom_range(3) == 0) c.param_first = 8'h00;
      if (c.opcode == OP_SETLOC && $urandom_range(1) == 0) begin
         c.param_count = 2'd3;
         c.param_first = {4'($urandom_range(7)), 4'($urandom_range(9))};
         c.param_second = {4'($urandom_range(5)), 4'($urandom_range(9))};
         c.param_third = {4'($urandom_range(7)), 4'($urandom_range(4))};
      end
      return c;
   endfunction

   initial begin
      req_type c;
      logic [7:0] ops[19];
      ops = '{OP_GETSTAT, OP_SETLOC, OP_PLAY, OP_FORWARD, OP_BACKWARD, OP_READN,
              OP_MOTORON, OP_STOP, OP_PAUSE, OP_INIT, OP_MUTE, OP_DEMUTE, OP_SETMODE,
              OP_GETTN, OP_GETTD, OP_SEEKL, OP_SEEKP, OP_TEST, OP_GETID};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 33;
      recv_idle_pct = 47;
      foreach (ops[i]) send_command(make_command(ops[i], 2'd3, 1'b0));
      c = make_command(OP_SETLOC, 2'd3, 1'b0);
      c.param_first = 8'h00; c.param_second = 8'h01; c.param_third = 8'h74;
      send_command(c);
      c.param_first = 8'hff; c.param_second = 8'hff; c.param_third = 8'hff;
      send_command(c);
      c = make_command(OP_TEST, 2'd0, 1'b0);
      c.param_first = 8'h20;
      send_command(c);
      send_command(make_command(8'hff, 2'd3, 1'b1));
      c = make_command(OP_GETTD, 2'd1, 1'b0);
      c.param_first = 8'h05; c.track_found = 1'b0;
      send_command(c);
      c = make_command(OP_PLAY, 2'd1, 1'b0);
      c.track_found = 1'b0;
      send_command(c);
      for (int k = 0; k < 4; k++) begin
         write_register(CSR_REGION, 19'(k));
         send_command(make_command(OP_GETID, 2'd0, 1'b1));
      end
      write_register(CSR_FIRST_TRACK, 19'd99);
      write_register(CSR_LAST_TRACK, 19'd99);
      write_register(CSR_LEAD_OUT, 19'd449999);
      c = make_command(OP_GETTD, 2'd0, 1'b0);
      send_command(c);
      send_command(make_command(OP_GETTN, 2'd0, 1'b0));
      for (int n = 0; n < 100; n++) begin
         if (n == 15) begin
            send_idle_pct = 47;
            recv_idle_pct = 33;
         end
         if (n == 58) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n % 30 == 29) begin
            write_register(CSR_FIRST_TRACK, 19'($urandom_range(1, 99)));
            write_register(CSR_LAST_TRACK, 19'($urandom_range(1, 99)));
            write_register(CSR_LEAD_OUT, 19'($urandom_range(449999)));
            write_register(CSR_REGION, 19'($urandom_range(3)));
         end
         send_command(random_command());
      end
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d commands and checked %0d response bytes across idle mixes",
               command_count, byte_count);
      $display("and several track, lead-out and region settings.");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
